// File: rtl/core/periodic_task_tick_table_core_defines.svh
// Assertion macros shared by the tick table checker.
// Depends on nothing; the asserting module provides clk_i and rst_ni.
`ifndef PERIODIC_TASK_TICK_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TASK_TICK_TABLE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ptt_pkg.sv
// Shared constants for the periodic task tick table: field widths,
// stream packing positions, operation, status and result kind codes.
package ptt_pkg;

  localparam int OpW       = 3;
  localparam int TaskKeyW  = 16;
  localparam int PeriodW   = 8;
  localparam int CountW    = 8;
  localparam int SlotResW  = 4;
  localparam int StatusW   = 3;

  localparam int InDataW   = 24;
  localparam int OutDataW  = 24;

  localparam int OutSlotLsb   = TaskKeyW;
  localparam int OutStatusLsb = TaskKeyW + SlotResW;

  localparam logic [OpW-1:0] OP_TICK   = 3'd0;
  localparam logic [OpW-1:0] OP_ADD    = 3'd1;
  localparam logic [OpW-1:0] OP_START  = 3'd2;
  localparam logic [OpW-1:0] OP_STOP   = 3'd3;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd4;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd2;
  localparam logic [StatusW-1:0] ST_PRESENT   = 3'd3;
  localparam logic [StatusW-1:0] ST_BAD_KEY   = 3'd4;

  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

endpackage

// File: rtl/core/periodic_task_tick_table_core.sv
// Periodic task tick table: one slot memory walked by a single compare/increment unit.
// Depends on ptt_pkg.
// A tick walks every slot in S_TICK and then S_FLUSH, plus output stalls; add, start, stop and
//   remove walk the slots in S_FIND (the walk stops early on a key match), then S_RESP.
// Throughput: one request per walk, set by the read port: one slot per cycle unless stalled.
// A finished result waits in the output register while the next request is taken.
// Reset clears all used flags at once (empty table); no clearing pass is needed.
module periodic_task_tick_table_core #(
  parameter int NUM_SLOTS = 10,
  parameter int KEY_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] task_key, [23:16] period
  input  logic [ptt_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [2:0] operation
  input  logic [ptt_pkg::OpW-1:0]       s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] task_key_res, [19:16] slot, [22:20] status, [23] zero
  output logic [ptt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [0] kind
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import ptt_pkg::*;

  localparam int KeyW    = (KEY_BITS < TaskKeyW) ? KEY_BITS : TaskKeyW;
  localparam int SlotW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastIdx = SlotW'(NUM_SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PeriodW-1:0] period;
    logic [CountW-1:0]  count;
    logic               running;
  } slot_t;

  slot_t mem_q [NUM_SLOTS];
  slot_t rd_q;
  slot_t mem_wdata;
  logic  mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [SlotW-1:0] rd_addr;

  logic [2:0]         state_q, state_d;
  logic [SlotW-1:0]   idx_q, idx_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic               pend_vld_q, pend_vld_d;
  logic [KeyW-1:0]    pend_key_q, pend_key_d;
  logic [SlotW-1:0]   pend_slot_q, pend_slot_d;
  logic               free_vld_q, free_vld_d;
  logic [SlotW-1:0]   free_q, free_d;
  logic [OpW-1:0]     op_q, op_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [PeriodW-1:0] per_q, per_d;
  logic [SlotW-1:0]   res_slot_q, res_slot_d;
  logic [StatusW-1:0] res_status_q, res_status_d;

  logic                out_valid_q, out_valid_d;
  logic                out_kind_q, out_kind_d;
  logic [TaskKeyW-1:0] out_key_q, out_key_d;
  logic [SlotResW-1:0] out_slot_q, out_slot_d;
  logic [StatusW-1:0]  out_status_q, out_status_d;
  logic                out_last_q, out_last_d;
  logic                out_load;
  logic                out_free;

  logic [KeyW-1:0]   in_key;
  logic [CountW-1:0] cnt_inc;
  logic              slot_live;
  logic              fire;
  logic              key_hit;
  logic              at_last;
  logic              free_here;
  logic [SlotW-1:0]  idx_next;
  logic [SlotW-1:0]  free_idx;

  assign in_key    = KeyW'(s_axis_tdata_i[TaskKeyW-1:0]);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign cnt_inc   = rd_q.count + CountW'(1);
  assign slot_live = used_q[idx_q] && rd_q.running;
  assign fire      = slot_live && (cnt_inc == rd_q.period);
  assign key_hit   = used_q[idx_q] && (rd_q.key == key_q);
  assign at_last   = (idx_q == LastIdx);
  assign idx_next  = at_last ? '0 : SlotW'(idx_q + SlotW'(1));
  assign free_here = !used_q[idx_q];
  assign free_idx  = free_vld_q ? free_q : idx_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    used_d       = used_q;
    pend_vld_d   = pend_vld_q;
    pend_key_d   = pend_key_q;
    pend_slot_d  = pend_slot_q;
    free_vld_d   = free_vld_q;
    free_d       = free_q;
    op_d         = op_q;
    key_d        = key_q;
    per_d        = per_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_q;
    out_load     = 1'b0;
    out_kind_d   = KIND_FIRE;
    out_key_d    = TaskKeyW'(pend_key_q);
    out_slot_d   = SlotResW'(pend_slot_q);
    out_status_d = ST_OK;
    out_last_d   = 1'b0;

    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (s_axis_tvalid_i) begin
          op_d       = s_axis_tuser_i;
          key_d      = in_key;
          per_d      = s_axis_tdata_i[TaskKeyW +: PeriodW];
          free_vld_d = 1'b0;
          case (s_axis_tuser_i) inside
            OP_TICK: state_d = S_TICK;
            OP_ADD, OP_START, OP_STOP, OP_REMOVE: begin
              if (in_key == '0) begin
                res_status_d = ST_BAD_KEY;
                res_slot_d   = '0;
                state_d      = S_RESP;
              end else begin
                state_d = S_FIND;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_TICK: begin
        // hold the slot while a second firing waits for the output register
        if (!(fire && pend_vld_q && !out_free)) begin
          if (slot_live) begin
            mem_we          = 1'b1;
            mem_wdata.count = fire ? '0 : cnt_inc;
          end
          if (fire) begin
            if (pend_vld_q) begin
              out_load = 1'b1;
            end
            pend_vld_d  = 1'b1;
            pend_key_d  = rd_q.key;
            pend_slot_d = idx_q;
          end
          idx_d = idx_next;
          if (at_last) begin
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      S_FIND: begin
        idx_d = idx_next;
        if (free_here && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_d     = idx_q;
        end
        if (key_hit) begin
          res_slot_d   = idx_q;
          res_status_d = ST_OK;
          state_d      = S_RESP;
          case (op_q)
            OP_ADD:    res_status_d = ST_PRESENT;
            OP_START: begin
              mem_we            = 1'b1;
              mem_wdata.running = 1'b1;
            end
            OP_STOP: begin
              mem_we            = 1'b1;
              mem_wdata.running = 1'b0;
            end
            default: begin
              used_d[idx_q] = 1'b0;
            end
          endcase
        end else if (at_last) begin
          state_d    = S_RESP;
          res_slot_d = '0;
          if (op_q == OP_ADD) begin
            if (free_vld_q || free_here) begin
              mem_we            = 1'b1;
              mem_waddr         = free_idx;
              mem_wdata.key     = key_q;
              mem_wdata.period  = per_q;
              mem_wdata.count   = '0;
              mem_wdata.running = 1'b0;
              used_d[free_idx]  = 1'b1;
              res_slot_d        = free_idx;
              res_status_d      = ST_OK;
            end else begin
              res_status_d = ST_FULL;
            end
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = KIND_STATUS;
          out_key_d    = TaskKeyW'(key_q);
          out_slot_d   = SlotResW'(res_slot_q);
          out_status_d = res_status_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign rd_addr     = idx_d;
  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      used_q      <= '0;
      pend_vld_q  <= 1'b0;
      free_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      used_q      <= used_d;
      pend_vld_q  <= pend_vld_d;
      free_vld_q  <= free_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_key_q   <= pend_key_d;
    pend_slot_q  <= pend_slot_d;
    free_q       <= free_d;
    op_q         <= op_d;
    key_q        <= key_d;
    per_q        <= per_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_key_q    <= out_key_d;
      out_slot_q   <= out_slot_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_status_q, out_slot_q, out_key_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: rtl/core/ptt_checker.sv
// Port-level checks for the periodic task tick table, bound to the core module.
// Depends on ptt_pkg and periodic_task_tick_table_core_defines.svh.
`include "periodic_task_tick_table_core_defines.svh"

module ptt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  // [2:0] operation
  input logic [ptt_pkg::OpW-1:0]       s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  // [15:0] task_key_res, [19:16] slot, [22:20] status, [23] zero
  input logic [ptt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [0] kind
  input logic                          m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);
  import ptt_pkg::*;

  logic [StatusW-1:0] out_status;
  logic               table_req;

  assign out_status = m_axis_tdata_o[OutStatusLsb +: StatusW];
  assign table_req  = (s_axis_tuser_i == OP_TICK) || (s_axis_tuser_i == OP_ADD) ||
                      (s_axis_tuser_i == OP_START) || (s_axis_tuser_i == OP_STOP) ||
                      (s_axis_tuser_i == OP_REMOVE);

  `PTT_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled result changed")
  `PTT_ASSERT_SAME(a_status_last, m_axis_tvalid_o && (m_axis_tuser_o == KIND_STATUS), m_axis_tlast_o, "status result not marked last")
  `PTT_ASSERT_SAME(a_fire_ok, m_axis_tvalid_o && (m_axis_tuser_o == KIND_FIRE), out_status == ST_OK, "fire result with nonzero status")
  `PTT_ASSERT_SAME(a_status_code, m_axis_tvalid_o, (out_status == ST_OK) || (out_status == ST_NOT_FOUND) || (out_status == ST_FULL) || (out_status == ST_PRESENT) || (out_status == ST_BAD_KEY), "status code out of range")
  `PTT_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid_i && s_axis_tready_o && table_req, !s_axis_tready_o, "ready right after a request")

endmodule

bind periodic_task_tick_table_core ptt_checker u_ptt_checker (.*);

// File: tb/periodic_task_tick_table_core_checker.sv
// Scoreboard for the periodic task tick table: mirrors the slot table, predicts the
// fire and status results of every accepted request and compares them in order.
// Depends on ptt_pkg.
`timescale 1ns / 1ps

module periodic_task_tick_table_core_checker #(
  parameter int NUM_SLOTS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [ptt_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [ptt_pkg::OpW-1:0]      s_axis_tuser_i,
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  input  logic [ptt_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  logic                         m_axis_tuser_i,
  input  logic                         m_axis_tlast_i,
  output int                           errors_o,
  output int                           pending_o
);
  import ptt_pkg::*;

  typedef struct packed {
    logic                kind;
    logic [TaskKeyW-1:0] key;
    logic [SlotResW-1:0] slot;
    logic [StatusW-1:0]  status;
    logic                last;
  } reply_t;

  logic [TaskKeyW-1:0] tbl_key    [NUM_SLOTS];
  logic [PeriodW-1:0]  tbl_period [NUM_SLOTS];
  logic [CountW-1:0]   tbl_count  [NUM_SLOTS];
  logic                tbl_run    [NUM_SLOTS];
  logic                tbl_used   [NUM_SLOTS];

  reply_t replies_due[$];
  int     error_count;
  int     pending_count;

  assign errors_o  = error_count;
  assign pending_o = pending_count;

  function automatic int find_slot(input logic [TaskKeyW-1:0] key);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_used[i] && tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic push_status(input logic [TaskKeyW-1:0] key, input int slot,
                             input logic [StatusW-1:0] status);
    reply_t r;
    r = '{kind: KIND_STATUS, key: key, slot: SlotResW'(slot), status: status, last: 1'b1};
    replies_due.push_back(r);
  endtask

  // Update the mirrored table for one request and queue the results it causes.
  task automatic predict_request(input logic [OpW-1:0] op, input logic [TaskKeyW-1:0] key,
                                 input logic [PeriodW-1:0] per);
    reply_t held;
    bit     have_held;
    int     hit;
    have_held = 1'b0;
    hit = -1;
    if (op == OP_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (tbl_used[i] && tbl_run[i]) begin
          tbl_count[i] = tbl_count[i] + 1'b1;
          if (tbl_count[i] == tbl_period[i]) begin
            tbl_count[i] = '0;
            if (have_held) replies_due.push_back(held);
            held = '{kind: KIND_FIRE, key: tbl_key[i], slot: SlotResW'(i), status: ST_OK,
                     last: 1'b0};
            have_held = 1'b1;
          end
        end
      end
      // mark the final fire of this tick
      if (have_held) begin
        held.last = 1'b1;
        replies_due.push_back(held);
      end
      return;
    end
    if (op > OP_REMOVE) return;
    if (key == '0) begin
      push_status(key, 0, ST_BAD_KEY);
      return;
    end
    hit = find_slot(key);
    if (op == OP_ADD) begin
      if (hit >= 0) begin
        push_status(key, hit, ST_PRESENT);
        return;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!tbl_used[i]) begin
          tbl_used[i]   = 1'b1;
          tbl_key[i]    = key;
          tbl_period[i] = per;
          tbl_count[i]  = '0;
          tbl_run[i]    = 1'b0;
          push_status(key, i, ST_OK);
          return;
        end
      end
      push_status(key, 0, ST_FULL);
      return;
    end
    if (hit < 0) begin
      push_status(key, 0, ST_NOT_FOUND);
      return;
    end
    case (op)
      OP_START: tbl_run[hit] = 1'b1;
      OP_STOP:  tbl_run[hit] = 1'b0;
      default: begin
        tbl_used[hit] = 1'b0;
        tbl_run[hit]  = 1'b0;
        tbl_key[hit]  = '0;
      end
    endcase
    push_status(key, hit, ST_OK);
  endtask

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      error_count++;
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0h data %h last %0h",
               $time, m_axis_tuser_i, m_axis_tdata_i, m_axis_tlast_i);
      error_count++;
      return;
    end
    want = replies_due.pop_front();
    compare_field("kind", want.kind, m_axis_tuser_i);
    compare_field("task key", want.key, m_axis_tdata_i[TaskKeyW-1:0]);
    compare_field("slot", want.slot, m_axis_tdata_i[OutSlotLsb +: SlotResW]);
    compare_field("status", want.status, m_axis_tdata_i[OutStatusLsb +: StatusW]);
    compare_field("last", want.last, m_axis_tlast_i);
    compare_field("pad bit", 0, m_axis_tdata_i[OutDataW-1]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tbl_key[i]    = '0;
        tbl_period[i] = '0;
        tbl_count[i]  = '0;
        tbl_run[i]    = 1'b0;
        tbl_used[i]   = 1'b0;
      end
      replies_due.delete();
      error_count   = 0;
      pending_count = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_request(s_axis_tuser_i, s_axis_tdata_i[TaskKeyW-1:0],
                        s_axis_tdata_i[TaskKeyW +: PeriodW]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) check_reply();
      pending_count = replies_due.size();
    end
  end

endmodule

// File: tb/periodic_task_tick_table_core_tb.sv
// Top of the tick table testbench: clock, reset, request and result stream drivers.
// Instantiates periodic_task_tick_table_core and its checker; depends on ptt_pkg.
`timescale 1ns / 1ps

module periodic_task_tick_table_core_tb;
  import ptt_pkg::*;

  localparam int NUM_SLOTS    = 10;
  localparam int KEY_BITS     = 16;
  localparam int POOL_SIZE    = 14;
  localparam int RANDOM_ITEMS = 260;
  localparam int WRAP_TICKS   = 256;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 30;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [OpW-1:0]      s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  int                  errors;
  int                  pending;

  logic [TaskKeyW-1:0] key_pool [POOL_SIZE];
  bit                  sender_fast = 1'b0;
  bit                  receiver_fast = 1'b0;

  always #4 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  periodic_task_tick_table_core #(
    .NUM_SLOTS(NUM_SLOTS),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  periodic_task_tick_table_core_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .m_axis_tlast_i (m_tlast),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input logic [OpW-1:0] op, input logic [TaskKeyW-1:0] key,
                              input logic [PeriodW-1:0] per);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {per, key};
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // Result side: random stalls, idle-free stretches and one long hold-off.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) receiver_fast = ($urandom_range(0, 3) == 0);
      stall = receiver_fast ? 0 : $urandom_range(0, 14);
      if (taken == HOLD_AT) stall = LONG_HOLD;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [OpW-1:0]      op;
    logic [TaskKeyW-1:0] key;
    logic [PeriodW-1:0]  per;
    int                  roll;
    int                  waited;

    // distinct nonzero keys: from index 1 on, the low nibble carries the pool index
    key_pool[0] = 16'hFFFF;
    key_pool[1] = 16'h0001;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {12'($urandom), 4'(i)};

    wait (rst_n);
    @(negedge clk);

    // directed: empty table, bad keys, duplicates, firing, removal, junk codes, full table
    send_request(OP_TICK, 16'h0000, 8'h00);
    send_request(OP_ADD, 16'h0000, 8'hFF);
    send_request(OP_START, 16'h0000, 8'h00);
    send_request(OP_STOP, 16'h0000, 8'h00);
    send_request(OP_START, key_pool[0], 8'h00);
    send_request(OP_ADD, key_pool[0], 8'd1);
    send_request(OP_ADD, key_pool[1], 8'd0);
    send_request(OP_ADD, key_pool[0], 8'hFF);
    send_request(OP_START, key_pool[0], 8'h00);
    send_request(OP_START, key_pool[1], 8'h00);
    send_request(OP_TICK, 16'hFFFF, 8'hFF);
    send_request(OP_TICK, 16'h0000, 8'h00);
    send_request(OP_ADD, key_pool[2], 8'hFF);
    send_request(OP_START, key_pool[2], 8'h00);
    send_request(OP_TICK, 16'h0000, 8'h00);
    send_request(OP_STOP, key_pool[0], 8'h00);
    send_request(OP_TICK, 16'h0000, 8'h00);
    send_request(OP_REMOVE, key_pool[1], 8'h00);
    send_request(OP_REMOVE, key_pool[1], 8'h00);
    send_request(3'd5, 16'hFFFF, 8'hFF);
    send_request(3'd7, key_pool[2], 8'h00);
    for (int i = 3; i <= 11; i++) send_request(OP_ADD, key_pool[i], 8'(i));

    // random: pool keys keep adds, starts and removes landing on real slots
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) sender_fast = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 45)      op = OP_TICK;
      else if (roll < 60) op = OP_ADD;
      else if (roll < 72) op = OP_START;
      else if (roll < 82) op = OP_STOP;
      else if (roll < 94) op = OP_REMOVE;
      else                op = 3'($urandom_range(5, 7));
      roll = $urandom_range(0, 99);
      if (roll < 5)                       key = '0;
      else if (roll < 10 && op != OP_ADD) key = 16'($urandom);
      else                                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 70)      per = 8'($urandom_range(1, 5));
      else if (roll < 80) per = 8'h00;
      else if (roll < 90) per = 8'hFF;
      else                per = 8'($urandom);
      send_request(op, key, per);
    end

    // counter wrap: empty the table, then run period 255 and period 0 for a full lap
    for (int i = 0; i < POOL_SIZE; i++) send_request(OP_REMOVE, key_pool[i], 8'h00);
    send_request(OP_ADD, key_pool[12], 8'h00);
    send_request(OP_ADD, key_pool[13], 8'hFF);
    send_request(OP_START, key_pool[12], 8'h00);
    send_request(OP_START, key_pool[13], 8'h00);
    for (int n = 0; n < WRAP_TICKS; n++) send_request(OP_TICK, 16'($urandom), 8'($urandom));
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4 * NUM_SLOTS) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: periodic_task_tick_table_core.f
+incdir+rtl/core
rtl/core/ptt_pkg.sv
rtl/core/periodic_task_tick_table_core.sv
rtl/core/ptt_checker.sv
tb/periodic_task_tick_table_core_checker.sv
tb/periodic_task_tick_table_core_tb.sv
